### hdl/esc_pkg.sv
package esc_pkg;

	localparam int FLOOR_W = 5;
	localparam int FUNC_W  = 2;
	localparam int DIR_W   = 2;
	localparam int MODE_W  = 2;
	localparam int EV_W    = 3;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	localparam logic [FUNC_W-1:0] FUNC_PRESS   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SERVICE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

	localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WORK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SERVE = 2'd2;

	localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EV_W-1:0] EV_GO      = 3'd1;
	localparam logic [EV_W-1:0] EV_REACHED = 3'd2;
	localparam logic [EV_W-1:0] EV_KEEP    = 3'd3;
	localparam logic [EV_W-1:0] EV_RESTART = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHOOSE,
		ST_SCAN,
		ST_DONE
	} esc_state_t;

endpackage

### hdl/elevator_scan_controller_unit.sv
// Elevator controller with SCAN-style target selection.
// Input channel (s_*): one transaction per event. s_tuser carries the event kind
// (press, tick, service done), s_tdata the floor of a button press.
// Output channel (m_*): exactly one result transaction per input transaction,
// carrying cabin floor, target floor, direction, mode, event code, the cleared
// floor and the reject flag.
// A tick, a rejected press or an unused kind passes from acceptance through the
// execute and done states into the output register. A press or service done walks
// the request bitmap one floor per cycle in a single scan unit: a press scans at
// most NUM_FLOORS+1 entries (sweep ahead, then back from the cabin); a service
// restart runs a lowest-floor search and then a directed search. s_tready is high
// only while no event is in work; it rises in the same cycle as m_tvalid, so the
// next transaction can be accepted then.
// A finished result sits in the output register; the next event is accepted
// while it waits, and its result is held back until m_tready takes the first.
// Reset: no requests pending, cabin and target at floor 1, stopped, free mode,
// output empty.
module elevator_scan_controller_unit #(
	parameter int NUM_FLOORS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [4:0] floor
	input  logic [esc_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] func
	input  logic [esc_pkg::FUNC_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [4:0] current_floor, [9:5] target_floor, [11:10] direction, [13:12] mode,
	// [16:14] event_res, [21:17] cleared_floor, [22] rejected
	output logic [esc_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import esc_pkg::*;

	localparam int IDX_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FLOORS - 1);

	esc_state_t state_q, state_d;

	logic [NUM_FLOORS-1:0] pend_q, pend_d;
	logic [FLOOR_W-1:0]    cabin_q, cabin_d;
	logic [FLOOR_W-1:0]    goal_q, goal_d;
	logic [DIR_W-1:0]      dir_q, dir_d;
	logic [MODE_W-1:0]     mode_q, mode_d;

	logic [FUNC_W-1:0]     func_q, func_d;
	logic [FLOOR_W-1:0]    floor_q, floor_d;
	logic [FLOOR_W-1:0]    pick_q, pick_d;
	logic                  svc_q, svc_d;     // search is the first one of a service done
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic                  up_q, up_d;
	logic                  low_q, low_d;     // lowest-pending search of a stopped lift
	logic                  second_q, second_d;
	logic [EV_W-1:0]       ev_q, ev_d;
	logic [FLOOR_W-1:0]    clr_q, clr_d;
	logic                  rej_q, rej_d;

	logic                  mvalid_q, mvalid_d;
	logic [OUT_DATA_W-1:0] mdata_q, mdata_d;

	logic [IDX_W-1:0]      cab_idx;
	logic [IDX_W-1:0]      fl_idx;
	logic [FLOOR_W-1:0]    hit_floor;
	logic                  scan_end;
	logic                  floor_bad;
	logic                  fin;
	logic                  hit;

	assign cab_idx   = IDX_W'(cabin_q - 5'd1);
	assign fl_idx    = IDX_W'(floor_q - 5'd1);
	assign hit_floor = FLOOR_W'(32'(idx_q) + 32'd1);
	assign scan_end  = up_q ? (idx_q == LAST_IDX) : (idx_q == '0);
	assign floor_bad = (floor_q == '0) || (32'(floor_q) > NUM_FLOORS);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_q   <= '0;
			cabin_q  <= 5'd1;
			goal_q   <= 5'd1;
			dir_q    <= DIR_STOP;
			mode_q   <= MODE_FREE;
			svc_q    <= 1'b0;
			up_q     <= 1'b0;
			low_q    <= 1'b0;
			second_q <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pend_q   <= pend_d;
			cabin_q  <= cabin_d;
			goal_q   <= goal_d;
			dir_q    <= dir_d;
			mode_q   <= mode_d;
			svc_q    <= svc_d;
			up_q     <= up_d;
			low_q    <= low_d;
			second_q <= second_d;
			mvalid_q <= mvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q  <= func_d;
		floor_q <= floor_d;
		pick_q  <= pick_d;
		idx_q   <= idx_d;
		ev_q    <= ev_d;
		clr_q   <= clr_d;
		rej_q   <= rej_d;
		mdata_q <= mdata_d;
	end

	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		cabin_d  = cabin_q;
		goal_d   = goal_q;
		dir_d    = dir_q;
		mode_d   = mode_q;
		func_d   = func_q;
		floor_d  = floor_q;
		pick_d   = pick_q;
		svc_d    = svc_q;
		idx_d    = idx_q;
		up_d     = up_q;
		low_d    = low_q;
		second_d = second_q;
		ev_d     = ev_q;
		clr_d    = clr_q;
		rej_d    = rej_q;
		mvalid_d = mvalid_q;
		mdata_d  = mdata_q;
		fin      = 1'b0;
		hit      = 1'b0;

		if (mvalid_q && m_tready) begin
			mvalid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					func_d  = s_tuser;
					floor_d = s_tdata[FLOOR_W-1:0];
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ev_d    = EV_NONE;
				clr_d   = '0;
				rej_d   = 1'b0;
				state_d = ST_DONE;
				unique case (func_q)
					FUNC_PRESS: begin
						if (floor_bad) begin
							rej_d = 1'b1;
						end else begin
							mode_d         = MODE_WORK;
							pend_d[fl_idx] = 1'b1;
							pick_d         = floor_q;
							svc_d          = 1'b0;
							ev_d           = EV_GO;
							state_d        = ST_CHOOSE;
						end
					end
					FUNC_TICK: begin
						if (cabin_q == goal_q) begin
							mode_d = MODE_SERVE;
							ev_d   = EV_REACHED;
						end else begin
							cabin_d = (cabin_q < goal_q) ? cabin_q + 5'd1 : cabin_q - 5'd1;
							ev_d    = EV_KEEP;
						end
					end
					FUNC_SERVICE: begin
						if (mode_q == MODE_WORK || mode_q == MODE_SERVE) begin
							dir_d           = DIR_STOP;
							mode_d          = MODE_FREE;
							pend_d[cab_idx] = 1'b0;
							clr_d           = cabin_q;
						end
						pick_d  = cabin_q;
						svc_d   = 1'b1;
						state_d = ST_CHOOSE;
					end
					default: ;
				endcase
			end
			ST_CHOOSE: begin
				second_d = 1'b0;
				state_d  = ST_SCAN;
				if (dir_q != DIR_STOP) begin
					idx_d = cab_idx;
					up_d  = (dir_q == DIR_UP);
					low_d = 1'b0;
				end else begin
					idx_d = '0;
					up_d  = 1'b1;
					low_d = 1'b1;
				end
			end
			ST_SCAN: begin
				priority if (pend_q[idx_q]) begin
					hit = 1'b1;
					fin = 1'b1;
					if (low_q) begin
						dir_d = (hit_floor > cabin_q) ? DIR_UP : DIR_DOWN;
					end
				end else if (scan_end) begin
					if (low_q || second_q) begin
						fin = 1'b1;
					end else begin
						// nothing ahead: reverse and sweep back from the cabin
						dir_d    = (dir_q == DIR_UP) ? DIR_DOWN : DIR_UP;
						second_d = 1'b1;
						idx_d    = cab_idx;
						up_d     = !up_q;
					end
				end else begin
					idx_d = up_q ? idx_q + IDX_W'(1) : idx_q - IDX_W'(1);
				end

				if (fin) begin
					if (svc_q) begin
						if (hit) begin
							// restart: behaves as a press of the found floor
							pick_d  = hit_floor;
							mode_d  = MODE_WORK;
							ev_d    = EV_RESTART;
							svc_d   = 1'b0;
							state_d = ST_CHOOSE;
						end else begin
							state_d = ST_DONE;
						end
					end else begin
						goal_d  = hit ? hit_floor : pick_q;
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (!mvalid_q || m_tready) begin
					mvalid_d = 1'b1;
					mdata_d  = {1'b0, rej_q, clr_q, ev_q, mode_q, dir_q, goal_q, cabin_q};
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_EXEC)
		else $error("accepted transaction did not start execution");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> 32'(idx_q) < NUM_FLOORS)
		else $error("scan index out of floor range");

	a_cabin_range: assert property (@(posedge clk) disable iff (!arst_n)
		cabin_q >= 5'd1 && 32'(cabin_q) <= NUM_FLOORS)
		else $error("cabin floor out of range");

	a_restart_moving: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && ev_q == EV_RESTART |-> mode_q == MODE_WORK && dir_q != DIR_STOP)
		else $error("restart left the lift stopped or not working");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && mvalid_q && !m_tready |=> state_q == ST_DONE)
		else $error("result overwrote a pending output");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import esc_pkg::*;

	typedef struct {
		logic [FLOOR_W-1:0] cur;
		logic [FLOOR_W-1:0] tgt;
		logic [DIR_W-1:0]   dir;
		logic [MODE_W-1:0]  mode;
		logic [EV_W-1:0]    ev;
		logic [FLOOR_W-1:0] cleared;
		logic               rej;
	} cabin_report_t;

	class elevator_scoreboard;
		int                 floors;
		logic [63:0]        pending;
		logic [FLOOR_W-1:0] cabin;
		logic [FLOOR_W-1:0] goal;
		logic [DIR_W-1:0]   dir;
		logic [MODE_W-1:0]  mode;
		cabin_report_t      reports[$];
		int                 errors;

		function new(int n);
			floors  = n;
			pending = '0;
			cabin   = 5'd1;
			goal    = 5'd1;
			dir     = DIR_STOP;
			mode    = MODE_FREE;
			errors  = 0;
		endfunction

		function int scan_from_cabin(int step);
			int i;
			i = int'(cabin) - 1;
			while (i >= 0 && i < floors) begin
				if (pending[i])
					return i + 1;
				i += step;
			end
			return 0;
		endfunction

		// Returns the picked floor, 0 when nothing is pending; may flip or set dir.
		function int pick_target();
			int hit;
			int step;
			if (dir == DIR_UP || dir == DIR_DOWN) begin
				step = (dir == DIR_UP) ? 1 : -1;
				hit = scan_from_cabin(step);
				if (hit != 0)
					return hit;
				dir = (dir == DIR_UP) ? DIR_DOWN : DIR_UP;
				return scan_from_cabin(-step);
			end
			for (int i = 0; i < floors; i++) begin
				if (pending[i]) begin
					dir = (i + 1 > int'(cabin)) ? DIR_UP : DIR_DOWN;
					return i + 1;
				end
			end
			return 0;
		endfunction

		function void press_floor(int fl);
			int hit;
			mode = MODE_WORK;
			pending[fl-1] = 1'b1;
			hit = pick_target();
			goal = (hit != 0) ? hit[FLOOR_W-1:0] : fl[FLOOR_W-1:0];
		endfunction

		function void note_event(logic [FUNC_W-1:0] func, logic [FLOOR_W-1:0] fl);
			cabin_report_t r;
			int hit;
			r.ev      = EV_NONE;
			r.cleared = '0;
			r.rej     = 1'b0;
			case (func)
				FUNC_PRESS: begin
					if (fl < 1 || int'(fl) > floors) begin
						r.rej = 1'b1;
					end else begin
						press_floor(int'(fl));
						r.ev = EV_GO;
					end
				end
				FUNC_TICK: begin
					if (cabin == goal) begin
						mode = MODE_SERVE;
						r.ev = EV_REACHED;
					end else begin
						cabin = (cabin < goal) ? cabin + 5'd1 : cabin - 5'd1;
						r.ev = EV_KEEP;
					end
				end
				FUNC_SERVICE: begin
					if (mode == MODE_WORK || mode == MODE_SERVE) begin
						dir = DIR_STOP;
						mode = MODE_FREE;
						pending[cabin-1] = 1'b0;
						r.cleared = cabin;
					end
					hit = pick_target();
					if (hit != 0) begin
						press_floor(hit);
						r.ev = EV_RESTART;
					end
				end
				default: ;
			endcase
			r.cur  = cabin;
			r.tgt  = goal;
			r.dir  = dir;
			r.mode = mode;
			reports.push_back(r);
		endfunction

		function void cmp_field(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] d);
			cabin_report_t r;
			if (reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual 0x%06h", $time, d);
				errors++;
				return;
			end
			r = reports.pop_front();
			cmp_field("current_floor", r.cur, d[4:0]);
			cmp_field("target_floor", r.tgt, d[9:5]);
			cmp_field("direction", r.dir, d[11:10]);
			cmp_field("mode", r.mode, d[13:12]);
			cmp_field("event_res", r.ev, d[16:14]);
			cmp_field("cleared_floor", r.cleared, d[21:17]);
			cmp_field("rejected", r.rej, d[22]);
			cmp_field("pad bit", 0, d[23]);
		endfunction
	endclass

	localparam int N_FLOORS = 16;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [FUNC_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	elevator_scoreboard sb = new(N_FLOORS);

	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int stall_cnt = 0;

	elevator_scan_controller_unit #(
		.NUM_FLOORS(N_FLOORS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// receiver side: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 400;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_cnt = $urandom_range(1, 18) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_event(s_tuser, s_tdata[FLOOR_W-1:0]);
		end
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task send_event(logic [FUNC_W-1:0] func, logic [FLOOR_W-1:0] fl);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {{(IN_DATA_W-FLOOR_W){1'b0}}, fl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task send_noise();
		if ($urandom_range(0, 1) == 0)
			send_event(FUNC_PRESS,
				($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(17, 31)));
		else
			send_event(FUNC_UNUSED, 5'($urandom_range(0, 31)));
	endtask

	initial begin
		int sent;
		int n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: rejects, unused kind, service while free, scans both ways
		send_event(FUNC_PRESS, 5'd0);
		send_event(FUNC_PRESS, 5'd17);
		send_event(FUNC_PRESS, 5'd31);
		send_event(FUNC_UNUSED, 5'd21);
		send_event(FUNC_UNUSED, 5'd0);
		send_event(FUNC_SERVICE, 5'd31);
		send_event(FUNC_TICK, 5'd0);
		send_event(FUNC_SERVICE, 5'd0);
		send_event(FUNC_PRESS, 5'd16);
		send_event(FUNC_PRESS, 5'd8);
		repeat (3) send_event(FUNC_TICK, 5'd31);
		send_event(FUNC_PRESS, 5'd1);
		repeat (5) send_event(FUNC_TICK, 5'd0);
		send_event(FUNC_SERVICE, 5'd0);
		send_event(FUNC_SERVICE, 5'd0);
		repeat (3) send_event(FUNC_TICK, 5'd0);
		send_event(FUNC_PRESS, 5'd16);

		// random: press / travel / service sequences with some noise
		sent = 0;
		while (sent < 900) begin
			if (sent >= 750)
				idle_on = 1'b0;
			if (sent == 300 || sent == 600)
				hold_req = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				send_noise();
				sent++;
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					send_event(FUNC_PRESS, 5'($urandom_range(1, N_FLOORS)));
					sent++;
				end
				n = $urandom_range(1, 18);
				repeat (n) begin
					if ($urandom_range(0, 15) == 0)
						send_noise();
					else
						send_event(FUNC_TICK, 5'($urandom_range(0, 31)));
					sent++;
				end
				if ($urandom_range(0, 5) != 0) begin
					send_event(FUNC_SERVICE, 5'($urandom_range(0, 31)));
					sent++;
				end
			end
		end
		s_tvalid <= 1'b0;

		while (sb.reports.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
